FILE: sv/pgmh_pkg.sv
// ----------------------------------------------------------------------------
// pgmh_pkg: shared types and constants of the PGM histogram unit
// Byte codes, header parser states, result phase codes and the bin write port.
// ----------------------------------------------------------------------------
`default_nettype none

package pgmh_pkg;

    // Histogram geometry
    localparam int BIN_DEPTH  = 256;
    localparam int BIN_AW     = $clog2(BIN_DEPTH);
    localparam int COUNT_BITS = 27;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Header tokens
    localparam int TOKEN_CHARS = 4;
    localparam int TOKLEN_W    = $clog2(TOKEN_CHARS + 1);
    localparam int VALUE_W     = 14;
    localparam logic [VALUE_W-1:0] VALUE_MAX = 14'd9999;
    // width * height of saturated values (9999 * 9999) fits in 27 bits
    localparam int AREA_W = 27;
    localparam int ACC_W  = VALUE_W + 4;

    // Byte codes
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Request codes
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // Phase codes shown on the result channel
    localparam logic [1:0] PCODE_HEADER = 2'd0;
    localparam logic [1:0] PCODE_PIXELS = 2'd1;
    localparam logic [1:0] PCODE_DONE   = 2'd2;
    localparam logic [1:0] PCODE_ERROR  = 2'd3;

    typedef enum logic [2:0] {
        PH_MAGIC,
        PH_WIDTH,
        PH_HEIGHT,
        PH_MAXVAL,
        PH_PIXELS,
        PH_DONE,
        PH_ERROR
    } phase_t;

    // One bin write
    typedef struct packed {
        logic                  en;
        logic [BIN_AW-1:0]     addr;
        logic [COUNT_BITS-1:0] data;
    } bin_wr_t;

    // Parser status after the current item
    typedef struct packed {
        logic [1:0]         phase;
        logic [VALUE_W-1:0] width;
        logic [VALUE_W-1:0] height;
        logic [VALUE_W-1:0] maxval;
        logic               range_err;
    } hdr_status_t;

    function automatic logic is_c_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) ||
               (b == CH_VT) || (b == CH_FF) || (b == CH_CR);
    endfunction

endpackage

`default_nettype wire

FILE: sv/pgmh_parser.sv
// ----------------------------------------------------------------------------
// pgmh_parser: PGM header parser and pixel sequencer
// Tokenizes the header, holds width, height and maxval, counts pixel bytes
// and flags which pixel bytes go to a histogram bin.
// ----------------------------------------------------------------------------
`default_nettype none

module pgmh_parser (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    step,
    input  wire logic                    req_type,
    input  wire logic [7:0]              data_byte,
    output logic                         pixel_hit,
    output pgmh_pkg::hdr_status_t        status
);

    pgmh_pkg::phase_t                   phase_reg, phase_next;
    logic                               comment_reg, comment_next;
    logic                               in_token_reg, in_token_next;
    logic [pgmh_pkg::TOKLEN_W-1:0]      token_length_reg, token_length_next;
    logic [pgmh_pkg::VALUE_W-1:0]       digit_value_reg, digit_value_next;
    logic                               digits_ended_reg, digits_ended_next;
    logic [pgmh_pkg::VALUE_W-1:0]       width_reg, width_next;
    logic [pgmh_pkg::VALUE_W-1:0]       height_reg, height_next;
    logic [pgmh_pkg::VALUE_W-1:0]       maxval_reg, maxval_next;
    logic [pgmh_pkg::AREA_W-1:0]        area_reg, area_next;
    logic [pgmh_pkg::AREA_W-1:0]        pixel_counter_reg, pixel_counter_next;
    logic                               range_reg, range_next;

    logic                               byte_step;
    logic                               in_range;
    logic                               is_digit;
    logic [2*pgmh_pkg::VALUE_W-1:0]     area_prod;

    assign byte_step = step && (req_type == pgmh_pkg::REQ_BYTE);
    assign is_digit  = (data_byte >= pgmh_pkg::CH_ZERO) && (data_byte <= pgmh_pkg::CH_NINE);
    assign in_range  = ({{(pgmh_pkg::VALUE_W-8){1'b0}}, data_byte} <= maxval_reg) &&
                       (32'(data_byte) < pgmh_pkg::BIN_DEPTH);
    // image area taken when the height token closes
    assign area_prod = {{pgmh_pkg::VALUE_W{1'b0}}, width_reg} *
                       {{pgmh_pkg::VALUE_W{1'b0}}, digit_value_reg};

    // Next state
    always_comb begin
        logic                          take;
        logic [pgmh_pkg::VALUE_W-1:0]  digit_base;
        logic                          ended_base;
        logic [pgmh_pkg::ACC_W-1:0]    acc;

        phase_next         = phase_reg;
        comment_next       = comment_reg;
        in_token_next      = in_token_reg;
        token_length_next  = token_length_reg;
        digit_value_next   = digit_value_reg;
        digits_ended_next  = digits_ended_reg;
        width_next         = width_reg;
        height_next        = height_reg;
        maxval_next        = maxval_reg;
        area_next          = area_reg;
        pixel_counter_next = pixel_counter_reg;
        range_next         = range_reg;
        take               = 1'b0;
        digit_base         = digit_value_reg;
        ended_base         = digits_ended_reg;

        if (byte_step) begin
            unique case (phase_reg)
                pgmh_pkg::PH_MAGIC, pgmh_pkg::PH_WIDTH,
                pgmh_pkg::PH_HEIGHT, pgmh_pkg::PH_MAXVAL: begin
                    if (in_token_reg) begin
                        if (pgmh_pkg::is_c_space(data_byte)) begin
                            // close the token and store its value
                            in_token_next = 1'b0;
                            unique case (phase_reg)
                                pgmh_pkg::PH_MAGIC: begin
                                    phase_next = pgmh_pkg::PH_WIDTH;
                                end
                                pgmh_pkg::PH_WIDTH: begin
                                    width_next = digit_value_reg;
                                    phase_next = pgmh_pkg::PH_HEIGHT;
                                end
                                pgmh_pkg::PH_HEIGHT: begin
                                    height_next = digit_value_reg;
                                    area_next   = area_prod[pgmh_pkg::AREA_W-1:0];
                                    phase_next  = pgmh_pkg::PH_MAXVAL;
                                end
                                default: begin
                                    maxval_next        = digit_value_reg;
                                    pixel_counter_next = '0;
                                    phase_next = (area_reg == '0) ? pgmh_pkg::PH_DONE
                                                                  : pgmh_pkg::PH_PIXELS;
                                end
                            endcase
                        end else if (token_length_reg >=
                                     pgmh_pkg::TOKLEN_W'(pgmh_pkg::TOKEN_CHARS)) begin
                            phase_next = pgmh_pkg::PH_ERROR;
                        end else begin
                            token_length_next = token_length_reg + 1'b1;
                            take              = 1'b1;
                        end
                    end else if (comment_reg) begin
                        if (data_byte == pgmh_pkg::CH_LF) begin
                            comment_next = 1'b0;
                        end
                    end else if (data_byte == pgmh_pkg::CH_HASH) begin
                        comment_next = 1'b1;
                    end else if ((data_byte != pgmh_pkg::CH_SPACE) &&
                                 (data_byte != pgmh_pkg::CH_TAB) &&
                                 (data_byte != pgmh_pkg::CH_LF)) begin
                        // open a new token
                        in_token_next     = 1'b1;
                        token_length_next = pgmh_pkg::TOKLEN_W'(1);
                        digit_base        = '0;
                        ended_base        = 1'b0;
                        take              = 1'b1;
                    end
                end
                pgmh_pkg::PH_PIXELS: begin
                    pixel_counter_next = pixel_counter_reg + 1'b1;
                    if (!in_range) begin
                        range_next = 1'b1;
                    end
                    if (pixel_counter_next >= area_reg) begin
                        phase_next = pgmh_pkg::PH_DONE;
                    end
                end
                default: begin
                end
            endcase
        end

        // accumulate leading decimal digits, saturating
        acc = (pgmh_pkg::ACC_W'(digit_base) * pgmh_pkg::ACC_W'(10)) +
              pgmh_pkg::ACC_W'(data_byte - pgmh_pkg::CH_ZERO);
        if (take) begin
            if (!ended_base && is_digit) begin
                digit_value_next  = (acc > pgmh_pkg::ACC_W'(pgmh_pkg::VALUE_MAX)) ?
                                    pgmh_pkg::VALUE_MAX : acc[pgmh_pkg::VALUE_W-1:0];
                digits_ended_next = 1'b0;
            end else begin
                digit_value_next  = digit_base;
                digits_ended_next = 1'b1;
            end
        end
    end

    // Outputs
    always_comb begin
        pixel_hit        = byte_step && (phase_reg == pgmh_pkg::PH_PIXELS) && in_range;
        status.width     = width_next;
        status.height    = height_next;
        status.maxval    = maxval_next;
        status.range_err = range_next;
        unique case (phase_next)
            pgmh_pkg::PH_MAGIC, pgmh_pkg::PH_WIDTH,
            pgmh_pkg::PH_HEIGHT, pgmh_pkg::PH_MAXVAL: status.phase = pgmh_pkg::PCODE_HEADER;
            pgmh_pkg::PH_PIXELS:                      status.phase = pgmh_pkg::PCODE_PIXELS;
            pgmh_pkg::PH_DONE:                        status.phase = pgmh_pkg::PCODE_DONE;
            default:                                  status.phase = pgmh_pkg::PCODE_ERROR;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= pgmh_pkg::PH_MAGIC;
            comment_reg       <= 1'b0;
            in_token_reg      <= 1'b0;
            token_length_reg  <= '0;
            digit_value_reg   <= '0;
            digits_ended_reg  <= 1'b0;
            width_reg         <= '0;
            height_reg        <= '0;
            maxval_reg        <= '0;
            area_reg          <= '0;
            pixel_counter_reg <= '0;
            range_reg         <= 1'b0;
        end else begin
            phase_reg         <= phase_next;
            comment_reg       <= comment_next;
            in_token_reg      <= in_token_next;
            token_length_reg  <= token_length_next;
            digit_value_reg   <= digit_value_next;
            digits_ended_reg  <= digits_ended_next;
            width_reg         <= width_next;
            height_reg        <= height_next;
            maxval_reg        <= maxval_next;
            area_reg          <= area_next;
            pixel_counter_reg <= pixel_counter_next;
            range_reg         <= range_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/pgmh_bins.sv
// ----------------------------------------------------------------------------
// pgmh_bins: histogram bin memory
// One registered read and one write per cycle, per-bin valid bits that reset
// clears, and forwarding of the last write to the following read.
// ----------------------------------------------------------------------------
`default_nettype none

module pgmh_bins (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              rd_en,
    input  wire logic [pgmh_pkg::BIN_AW-1:0]       rd_addr,
    output logic [pgmh_pkg::COUNT_BITS-1:0]        rd_data,
    input  wire pgmh_pkg::bin_wr_t                 wr
);

    logic [pgmh_pkg::COUNT_BITS-1:0] mem [pgmh_pkg::BIN_DEPTH];
    logic [pgmh_pkg::COUNT_BITS-1:0] rd_q_reg;
    logic [pgmh_pkg::BIN_AW-1:0]     rd_addr_reg;
    logic [pgmh_pkg::BIN_DEPTH-1:0]  valid_reg;
    pgmh_pkg::bin_wr_t               fwd_reg;

    // Memory port
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en) begin
            rd_q_reg    <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    // Mark written bins; remember the last write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            fwd_reg   <= '0;
        end else if (wr.en) begin
            valid_reg[wr.addr] <= 1'b1;
            fwd_reg            <= wr;
        end
    end

    // Select forwarded, stored or reset count
    always_comb begin
        if (fwd_reg.en && (fwd_reg.addr == rd_addr_reg)) begin
            rd_data = fwd_reg.data;
        end else if (valid_reg[rd_addr_reg]) begin
            rd_data = rd_q_reg;
        end else begin
            rd_data = '0;
        end
    end

endmodule

`default_nettype wire

FILE: sv/pgm_stream_histogram_unit.sv
// ----------------------------------------------------------------------------
// pgm_stream_histogram_unit: gray-level histogram of a binary PGM byte stream
// Input channel s_*: one item per byte of the file (req_type 0) or per bin
// read (req_type 1). Result channel m_*: one result per item, in order,
// carrying the phase, the parsed header values, the range flag and, for a
// bin read, the bin count.
// An accepted item passes the input register, then the result register,
// before its result is valid. Throughput: one item per cycle while the
// receiver takes results; the bin memory's single read and write port
// with forwarding of the last update sets that figure.
// Reset (aresetn low at a clock edge) returns the parser to the start of
// the header and clears every bin at once through per-bin valid bits; the
// block is ready for items as soon as reset is released.
// When the receiver stalls, the result register holds its item, the input
// register still fills, and s_ready drops only while both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module pgm_stream_histogram_unit (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_req_type,
    input  wire logic [7:0]                         s_data_byte,
    input  wire logic [7:0]                         s_bin_index,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [1:0]                              m_phase,
    output logic [pgmh_pkg::COUNT_BITS-1:0]         m_bin_count,
    output logic [pgmh_pkg::VALUE_W-1:0]            m_image_width,
    output logic [pgmh_pkg::VALUE_W-1:0]            m_image_height,
    output logic [pgmh_pkg::VALUE_W-1:0]            m_max_value,
    output logic                                    m_range_error
);

    logic                                s_accept;
    logic                                s1_fire;
    logic                                s1_valid_reg;
    logic                                s1_req_reg;
    logic [7:0]                          s1_byte_reg;
    logic [7:0]                          s1_index_reg;
    logic                                m_valid_reg;
    logic [pgmh_pkg::BIN_AW-1:0]         rd_addr;
    logic [pgmh_pkg::COUNT_BITS-1:0]     rd_data;
    logic [pgmh_pkg::COUNT_BITS-1:0]     count_out;
    logic                                pixel_hit;
    pgmh_pkg::bin_wr_t                   bin_wr;
    pgmh_pkg::hdr_status_t               status;

    // Handshake
    assign s1_fire  = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !s1_valid_reg || s1_fire;
    assign s_accept = s_valid && s_ready;
    assign m_valid  = m_valid_reg;

    // Read the bin the item addresses while it enters the input register
    assign rd_addr = (s_req_type == pgmh_pkg::REQ_READ) ? pgmh_pkg::BIN_AW'(s_bin_index)
                                                        : pgmh_pkg::BIN_AW'(s_data_byte);

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_fire) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_req_reg   <= s_req_type;
            s1_byte_reg  <= s_data_byte;
            s1_index_reg <= s_bin_index;
        end
    end

    pgmh_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (s1_fire),
        .req_type  (s1_req_reg),
        .data_byte (s1_byte_reg),
        .pixel_hit (pixel_hit),
        .status    (status)
    );

    pgmh_bins u_bins (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr      (bin_wr)
    );

    // Increment the pixel's bin, saturating
    always_comb begin
        bin_wr.en   = pixel_hit && (rd_data != pgmh_pkg::COUNT_MAX);
        bin_wr.addr = pgmh_pkg::BIN_AW'(s1_byte_reg);
        bin_wr.data = rd_data + 1'b1;
    end

    // Count returned only for reads of an existing bin
    assign count_out = ((s1_req_reg == pgmh_pkg::REQ_READ) &&
                        (32'(s1_index_reg) < pgmh_pkg::BIN_DEPTH)) ? rd_data : '0;

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            m_phase        <= status.phase;
            m_bin_count    <= count_out;
            m_image_width  <= status.width;
            m_image_height <= status.height;
            m_max_value    <= status.maxval;
            m_range_error  <= status.range_err;
        end
    end

endmodule

`default_nettype wire

FILE: sv/pgmh_checker.sv
// ----------------------------------------------------------------------------
// pgmh_checker: port-level checks of the PGM histogram unit
// Watches the result channel for reset behavior, stall hold and sticky flags.
// ----------------------------------------------------------------------------
`default_nettype none

module pgmh_checker (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              m_valid,
    input  wire logic                              m_ready,
    input  wire logic [1:0]                        m_phase,
    input  wire logic [pgmh_pkg::COUNT_BITS-1:0]   m_bin_count,
    input  wire logic                              m_range_error
);

    logic seen_range_reg;
    logic seen_error_reg;

    // Track sticky flags over delivered items
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_range_reg <= 1'b0;
            seen_error_reg <= 1'b0;
        end else if (m_valid && m_ready) begin
            if (m_range_error) begin
                seen_range_reg <= 1'b1;
            end
            if (m_phase == pgmh_pkg::PCODE_ERROR) begin
                seen_error_reg <= 1'b1;
            end
        end
    end

    // No result right after reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // Stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_phase) && $stable(m_bin_count)))
        else $error("stalled result changed");

    // Range flag stays set
    a_range_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && seen_range_reg) |-> m_range_error)
        else $error("range flag cleared");

    // Token error phase stays
    a_error_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && seen_error_reg) |-> (m_phase == pgmh_pkg::PCODE_ERROR))
        else $error("error phase left");

endmodule

bind pgm_stream_histogram_unit pgmh_checker u_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_phase       (m_phase),
    .m_bin_count   (m_bin_count),
    .m_range_error (m_range_error)
);

`default_nettype wire
